FILE: rtl/rbe_pkg.sv
`default_nettype none
package rbe_pkg;

	localparam int unsigned SecsPerMin  = 60;
	localparam int unsigned SecsPerHour = 60 * SecsPerMin;
	localparam int unsigned SecsPerDay  = 24 * SecsPerHour;
	localparam int unsigned DaysPerYear = 365;
	localparam int unsigned YearWindow  = 70;
	localparam int unsigned YearSpan    = 100;
	localparam int unsigned MonthMax    = 12;

	typedef struct packed {
		logic [7:0] sec_bcd;
		logic [7:0] min_bcd;
		logic [7:0] hour_bcd;
		logic [7:0] mday_bcd;
		logic [7:0] month_bcd;
		logic [7:0] year_bcd;
	} req_t;

	typedef struct packed {
		logic [31:0] epoch_seconds;
		logic [8:0]  year_day;
		logic        bad_input;
	} rsp_t;

	// Decoded snapshot handed from the decoder into the pipeline.
	typedef struct packed {
		logic       bad;
		logic [6:0] sec;
		logic [6:0] min;
		logic [6:0] hour;
		logic [6:0] mday;
		logic [6:0] years;
		logic [4:0] leaps;
		logic [8:0] dbm;
		logic       feb_fix;
	} dec_t;

	function automatic logic bcd_ok(input logic [7:0] b);
		return (b[7:4] <= 4'd9) && (b[3:0] <= 4'd9);
	endfunction

	function automatic logic [6:0] bcd_bin(input logic [7:0] b);
		return 7'({3'b000, b[7:4]} * 7'd10) + {3'b000, b[3:0]};
	endfunction

	// Days before the first of each month, February taken as 29 days.
	function automatic logic [8:0] days_before_month(input logic [6:0] mon);
		logic [8:0] d;
		case (mon)
			7'd1:    d = 9'd0;
			7'd2:    d = 9'd31;
			7'd3:    d = 9'd60;
			7'd4:    d = 9'd91;
			7'd5:    d = 9'd121;
			7'd6:    d = 9'd152;
			7'd7:    d = 9'd182;
			7'd8:    d = 9'd213;
			7'd9:    d = 9'd244;
			7'd10:   d = 9'd274;
			7'd11:   d = 9'd305;
			7'd12:   d = 9'd335;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/rbe_decode.sv
`default_nettype none
module rbe_decode import rbe_pkg::*; (
	input  req_t snap,
	output dec_t dec
);

	logic [6:0] mon;
	logic [6:0] yr2;
	logic [6:0] years;
	logic [6:0] years_p1;
	logic [1:0] years_p2;
	logic       mon_bad;
	logic       nib_bad;

	assign mon = bcd_bin(snap.month_bcd);
	assign yr2 = bcd_bin(snap.year_bcd);

	assign nib_bad = !bcd_ok(snap.sec_bcd) || !bcd_ok(snap.min_bcd)
		|| !bcd_ok(snap.hour_bcd) || !bcd_ok(snap.mday_bcd)
		|| !bcd_ok(snap.month_bcd) || !bcd_ok(snap.year_bcd);
	assign mon_bad = (mon == 7'd0) || (mon > 7'(MonthMax));

	// Window the two-digit year onto 1970..2069.
	assign years = (yr2 >= 7'(YearWindow)) ? yr2 - 7'(YearWindow)
		: yr2 + 7'(YearSpan - YearWindow);
	assign years_p1 = years + 7'd1;
	assign years_p2 = years[1:0] + 2'd2;

	always_comb begin
		dec.bad     = nib_bad || mon_bad;
		dec.sec     = bcd_bin(snap.sec_bcd);
		dec.min     = bcd_bin(snap.min_bcd);
		dec.hour    = bcd_bin(snap.hour_bcd);
		dec.mday    = bcd_bin(snap.mday_bcd);
		dec.years   = years;
		dec.leaps   = years_p1[6:2];
		dec.dbm     = days_before_month(mon);
		// Drop the assumed leap day after February in a common year.
		dec.feb_fix = (years_p2 != 2'd0) && (mon > 7'd2);
	end

endmodule
`default_nettype wire

FILE: rtl/rtc_bcd_date_to_epoch_seconds.sv
`default_nettype none
// BCD RTC snapshot to seconds since 1970-01-01 and day of year.
// Stages: s1 (decode), s2 (day count and seconds of day), s3 (day count
// times 86400, output register). One snapshot per cycle while rsp is not
// stalled. A stall on rsp holds each full stage whose later stages are all
// full; req_stall rises only when s1, s2 and s3 are full and rsp stalls.
// Reset (arst_n low) clears the stage valid bits; data registers are not reset.
module rtc_bcd_date_to_epoch_seconds import rbe_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	dec_t dec;

	logic adv1, adv2, adv3;
	logic valid_s1, valid_s2, valid_s3;

	dec_t dec_s1;

	logic               bad_s2;
	logic signed [16:0] days_s2;
	logic [18:0]        sod_s2;
	logic [8:0]         yday_s2;

	rsp_t rsp_s3;

	logic [16:0] days_sum;
	logic [18:0] sod_sum;
	logic [8:0]  yday_sum;
	logic [31:0] epoch_sum;

	rbe_decode u_decode (
		.snap (req),
		.dec  (dec)
	);

	assign adv3 = !valid_s3 || !rsp_stall;
	assign adv2 = !valid_s2 || adv3;
	assign adv1 = !valid_s1 || adv2;

	assign req_stall = !adv1;
	assign rsp_valid = valid_s3;
	assign rsp       = rsp_s3;

	// Stage 2 math: whole days since the epoch, which may be -1 for a zero day.
	assign days_sum = 17'({10'd0, dec_s1.years} * 17'(DaysPerYear))
		+ {12'd0, dec_s1.leaps} + {8'd0, dec_s1.dbm} - {16'd0, dec_s1.feb_fix}
		+ {10'd0, dec_s1.mday} - 17'd1;
	assign sod_sum = 19'({12'd0, dec_s1.hour} * 19'(SecsPerHour))
		+ 19'({12'd0, dec_s1.min} * 19'(SecsPerMin)) + {12'd0, dec_s1.sec};
	assign yday_sum = dec_s1.dbm + {2'd0, dec_s1.mday} - {8'd0, dec_s1.feb_fix};

	assign epoch_sum = 32'(32'(days_s2) * 32'(SecsPerDay)) + {13'd0, sod_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv1) valid_s1 <= req_valid;
			if (adv2) valid_s2 <= valid_s1;
			if (adv3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			dec_s1 <= dec;
		end
		if (adv2) begin
			bad_s2  <= dec_s1.bad;
			days_s2 <= signed'(days_sum);
			sod_s2  <= sod_sum;
			yday_s2 <= yday_sum;
		end
		if (adv3) begin
			if (bad_s2) begin
				rsp_s3.epoch_seconds <= '0;
				rsp_s3.year_day      <= '0;
				rsp_s3.bad_input     <= 1'b1;
			end else begin
				rsp_s3.epoch_seconds <= epoch_sum;
				rsp_s3.year_day      <= yday_s2;
				rsp_s3.bad_input     <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

FILE: sim/rtc_bcd_date_to_epoch_seconds_tb.sv
`timescale 1ns / 1ps

module rtc_bcd_date_to_epoch_seconds_tb;
	import rbe_pkg::*;

	typedef struct packed {
		req_t snap;
		logic drain;
		logic hold;
		logic tight;
	} snap_job_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	snap_job_t pending_snaps[$];
	rsp_t due_results[$];
	int unsigned mismatch_cnt = 0;
	int unsigned gap_left = 0;
	int unsigned hold_asks = 0;
	int unsigned hold_done = 0;
	int unsigned hold_left = 0;
	int unsigned stall_left = 0;
	int unsigned open_left = 0;

	rtc_bcd_date_to_epoch_seconds u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always #10 clk = ~clk;

	function automatic int unsigned month_days(input int unsigned mon, input int unsigned feb);
		if (mon == 2) return feb;
		if (mon == 4 || mon == 6 || mon == 9 || mon == 11) return 30;
		return 31;
	endfunction

	function automatic logic [7:0] to_bcd(input int unsigned v);
		return {4'(v / 10), 4'(v % 10)};
	endfunction

	function automatic req_t snap(input logic [7:0] s, input logic [7:0] mi,
		input logic [7:0] h, input logic [7:0] d, input logic [7:0] mo, input logic [7:0] y);
		req_t r;
		r.sec_bcd   = s;
		r.min_bcd   = mi;
		r.hour_bcd  = h;
		r.mday_bcd  = d;
		r.month_bcd = mo;
		r.year_bcd  = y;
		return r;
	endfunction

	function automatic rsp_t date_to_epoch(input req_t s);
		logic [7:0] b [6];
		int unsigned v [6];
		logic bad;
		int unsigned yrs;
		int unsigned prior_days;
		int unsigned fix;
		int unsigned day_cnt;
		rsp_t r;
		b[0] = s.sec_bcd;
		b[1] = s.min_bcd;
		b[2] = s.hour_bcd;
		b[3] = s.mday_bcd;
		b[4] = s.month_bcd;
		b[5] = s.year_bcd;
		bad = 1'b0;
		for (int i = 0; i < 6; i++) begin
			if (b[i][7:4] > 4'd9 || b[i][3:0] > 4'd9) bad = 1'b1;
			v[i] = int'(b[i][7:4]) * 10 + int'(b[i][3:0]);
		end
		if (v[4] < 1 || v[4] > MonthMax) bad = 1'b1;
		r = '0;
		if (bad) begin
			r.bad_input = 1'b1;
			return r;
		end
		yrs = (v[5] >= YearWindow) ? v[5] - YearWindow : v[5] + YearSpan - YearWindow;
		// February counts 29 days; take one back past February in common years
		prior_days = 0;
		for (int unsigned m = 1; m < v[4]; m++) prior_days += month_days(m, 29);
		fix = (((yrs + 2) % 4) != 0 && v[4] > 2) ? 1 : 0;
		// unsigned 32-bit math wraps just like the block does for day 0
		day_cnt = DaysPerYear * yrs + (yrs + 1) / 4 + prior_days - fix + v[3] - 1;
		r.epoch_seconds = SecsPerDay * day_cnt + SecsPerHour * v[2] + SecsPerMin * v[1] + v[0];
		r.year_day = 9'(prior_days + v[3] - fix);
		return r;
	endfunction

	function automatic req_t random_snap();
		int unsigned pick;
		int unsigned yr;
		int unsigned mon;
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			yr = $urandom_range(0, 99);
			mon = $urandom_range(1, 12);
			return snap(to_bcd($urandom_range(0, 59)), to_bcd($urandom_range(0, 59)),
				to_bcd($urandom_range(0, 23)),
				to_bcd($urandom_range(1, month_days(mon, (yr % 4 == 0) ? 29 : 28))),
				to_bcd(mon), to_bcd(yr));
		end
		if (pick < 85) begin
			// legal BCD digits, but no range check on anything but the month
			return snap({4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))},
				{4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))},
				{4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))},
				{4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))},
				to_bcd($urandom_range(1, 12)),
				{4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))});
		end
		return snap(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
			($urandom_range(0, 1) == 0) ? 8'($urandom) : to_bcd($urandom_range(1, 12)),
			8'($urandom));
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 65) return 0;
		if (pick < 88) return $urandom_range(1, 3);
		if (pick < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic queue_snap(input req_t s, input logic drain, input logic hold,
		input logic tight);
		snap_job_t job;
		job.snap  = s;
		job.drain = drain;
		job.hold  = hold;
		job.tight = tight;
		pending_snaps.push_back(job);
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		if (mismatch_cnt < 40)
			$display("%0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
		mismatch_cnt++;
	endtask

	// Sender: offer the next pending snapshot, hold it while stalled
	always @(posedge clk) begin : drive
		snap_job_t job;
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && !req_stall) due_results.push_back(date_to_epoch(req));
			if (!req_valid || !req_stall) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					req_valid <= 1'b0;
				end else if (pending_snaps.size() != 0 &&
					!(pending_snaps[0].drain && due_results.size() != 0)) begin
					job = pending_snaps.pop_front();
					req <= job.snap;
					req_valid <= 1'b1;
					gap_left <= job.tight ? 0 : pick_gap();
					if (job.hold) hold_asks <= hold_asks + 1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off, armed by the sender
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_done != hold_asks) begin
			hold_left <= 80;
			hold_done <= hold_done + 1;
		end
	end

	// Receiver stall pattern: short bursts, a few long ones, and open stretches
	always @(posedge clk) begin : receive_stall
		int unsigned pick;
		if (hold_left != 0) begin
			rsp_stall <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			rsp_stall <= 1'b1;
		end else if (open_left != 0) begin
			open_left <= open_left - 1;
			rsp_stall <= 1'b0;
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 55) open_left <= $urandom_range(1, 4);
			else if (pick < 83) stall_left <= $urandom_range(1, 3);
			else if (pick < 95) stall_left <= $urandom_range(5, 20);
			else open_left <= $urandom_range(60, 200);
			rsp_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin : check
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (due_results.size() == 0) begin
				report_mismatch("unexpected transaction", rsp.epoch_seconds, 0);
			end else begin
				want = due_results.pop_front();
				if (rsp.epoch_seconds !== want.epoch_seconds)
					report_mismatch("epoch_seconds", rsp.epoch_seconds, want.epoch_seconds);
				if (rsp.year_day !== want.year_day)
					report_mismatch("year_day", 32'(rsp.year_day), 32'(want.year_day));
				if (rsp.bad_input !== want.bad_input)
					report_mismatch("bad_input", 32'(rsp.bad_input), 32'(want.bad_input));
			end
		end
	end

	initial begin
		#10_000_000;
		$display("rtc_bcd_date_to_epoch_seconds_tb: errors");
		$finish;
	end

	initial begin
		logic tight;
		// Directed: epoch start, window edges, leap handling, unchecked ranges, bad codes
		queue_snap(snap(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h70), 0, 0, 0);
		queue_snap(snap(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h69), 0, 0, 0);
		queue_snap(snap(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99), 0, 0, 0);
		queue_snap(snap(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00), 0, 0, 0);
		queue_snap(snap(8'h12, 8'h34, 8'h12, 8'h29, 8'h02, 8'h72), 0, 0, 0);
		queue_snap(snap(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h72), 0, 0, 0);
		queue_snap(snap(8'h59, 8'h59, 8'h23, 8'h28, 8'h02, 8'h73), 0, 0, 0);
		queue_snap(snap(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h73), 0, 0, 0);
		queue_snap(snap(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h00), 0, 0, 0);
		queue_snap(snap(8'h00, 8'h00, 8'h00, 8'h31, 8'h12, 8'h72), 0, 0, 0);
		queue_snap(snap(8'h99, 8'h99, 8'h99, 8'h99, 8'h12, 8'h99), 0, 0, 0);
		queue_snap(snap(8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h70), 0, 0, 0);
		queue_snap(snap(8'h00, 8'h00, 8'h00, 8'h00, 8'h03, 8'h71), 0, 0, 0);
		queue_snap(snap(8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h70), 0, 0, 0);
		queue_snap(snap(8'h00, 8'h00, 8'h00, 8'h01, 8'h13, 8'h70), 0, 0, 0);
		queue_snap(snap(8'h00, 8'h00, 8'h00, 8'h01, 8'h1A, 8'h70), 0, 0, 0);
		queue_snap(snap(8'h0A, 8'h00, 8'h00, 8'h01, 8'h01, 8'h70), 0, 0, 0);
		queue_snap(snap(8'h00, 8'hF0, 8'h00, 8'h01, 8'h01, 8'h70), 0, 0, 0);
		queue_snap(snap(8'h00, 8'h00, 8'h0F, 8'h01, 8'h01, 8'h70), 0, 0, 0);
		queue_snap(snap(8'h00, 8'h00, 8'h00, 8'hA1, 8'h01, 8'h70), 0, 0, 0);
		queue_snap(snap(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h7B), 0, 0, 0);
		queue_snap(snap(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 0, 0, 0);
		queue_snap(snap(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 0, 0, 0);
		// Random: pause for a full drain now and then, and hold off the receiver twice
		for (int i = 0; i < 650; i++) begin
			tight = (i >= 100 && i < 140) || (i >= 420 && i < 460);
			queue_snap(random_snap(),
				i == 0 || i == 250 || i == 500 || $urandom_range(0, 99) == 0,
				i == 100 || i == 420, tight);
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_snaps.size() != 0 || req_valid || due_results.size() != 0)
			@(negedge clk);
		repeat (10) @(posedge clk);
		@(negedge clk);
		if (due_results.size() != 0)
			report_mismatch("results never delivered", due_results.size(), 0);
		if (mismatch_cnt == 0)
			$display("rtc_bcd_date_to_epoch_seconds_tb: clean");
		else
			$display("rtc_bcd_date_to_epoch_seconds_tb: errors");
		$finish;
	end

endmodule
